// File: src/sprite_quad_transform_defines.svh
// Assertion macros for the checker file of the sprite quad block.
`ifndef SPRITE_QUAD_TRANSFORM_DEFINES_SVH
`define SPRITE_QUAD_TRANSFORM_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SQT_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("sprite_quad_transform: check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SQT_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("sprite_quad_transform: check failed");

`endif

// File: src/sqt_pkg.sv
package sqt_pkg;

  // Angle resolution: 2^ANGLE_BITS steps per turn.
  localparam int ANGLE_BITS   = 12;
  localparam int QUARTER_BITS = ANGLE_BITS - 2;
  localparam int QUARTER      = 1 << QUARTER_BITS;
  localparam int INTERP_W     = QUARTER_BITS + 12;

  localparam int NUM_CORNERS  = 4;
  localparam int CORNER_BITS  = 2;

  // Offset products and rotated sums.
  localparam int SCALED_W     = 32;
  localparam int PROD_W       = 49;
  localparam int SUM_W        = 50;
  localparam int CENTER_W     = 18;
  localparam int CENTER_SHIFT = 26;
  localparam int OUT_SHIFT    = 27;

  localparam logic [14:0] SINE_ONE = 15'd16384;

  typedef logic [ANGLE_BITS-1:0] angle_t;
  typedef logic signed [15:0]    trig_t;

  typedef struct packed {
    logic signed [15:0] left_x;
    logic signed [15:0] top_y;
    logic [15:0]        width;
    logic [15:0]        height;
    logic [15:0]        scale_x;
    logic [15:0]        scale_y;
    logic [11:0]        angle;
    logic [15:0]        tex_x;
    logic [15:0]        tex_y;
    logic [15:0]        tex_w;
    logic [15:0]        tex_h;
    logic [31:0]        colour;
  } sprite_t;

  typedef struct packed {
    logic [CORNER_BITS-1:0] corner;
    logic signed [15:0]     x;
    logic signed [15:0]     y;
    logic [15:0]            u;
    logic [15:0]            v;
    logic [31:0]            colour;
    logic                   last;
  } vertex_t;

  // Quarter-wave sine, Q1.14, at steps of 1/64 turn.
  function automatic logic [14:0] quarter_sine_lut(input logic [4:0] idx);
    logic [14:0] val;
    unique case (idx)
      5'd0:    val = 15'd0;
      5'd1:    val = 15'd1606;
      5'd2:    val = 15'd3196;
      5'd3:    val = 15'd4756;
      5'd4:    val = 15'd6270;
      5'd5:    val = 15'd7723;
      5'd6:    val = 15'd9102;
      5'd7:    val = 15'd10394;
      5'd8:    val = 15'd11585;
      5'd9:    val = 15'd12665;
      5'd10:   val = 15'd13623;
      5'd11:   val = 15'd14449;
      5'd12:   val = 15'd15137;
      5'd13:   val = 15'd15678;
      5'd14:   val = 15'd16069;
      5'd15:   val = 15'd16305;
      default: val = SINE_ONE;
    endcase
    return val;
  endfunction

  // Interpolated sine over a quarter turn, q in 0..QUARTER, rounded half up.
  function automatic logic [14:0] sine_quarter(input logic [QUARTER_BITS:0] q);
    logic [4:0]              seg;
    logic [QUARTER_BITS-1:0] frac;
    logic [14:0]             lo;
    logic [14:0]             diff;
    logic [INTERP_W-1:0]     prod;
    seg  = 5'(q >> (QUARTER_BITS - 4));
    frac = {q[QUARTER_BITS-5:0], 4'b0000};
    if (seg >= 5'd16) begin
      return SINE_ONE;
    end
    lo   = quarter_sine_lut(seg);
    diff = quarter_sine_lut(seg + 5'd1) - lo;
    prod = INTERP_W'(diff[10:0]) * INTERP_W'(frac)
         + (INTERP_W'(1) << (QUARTER_BITS - 1));
    return lo + 15'(prod >> QUARTER_BITS);
  endfunction

  // Full-turn sine by quadrant symmetry.
  function automatic trig_t sine_full(input angle_t a);
    logic [1:0]              quad;
    logic [QUARTER_BITS-1:0] r;
    logic [QUARTER_BITS:0]   q;
    trig_t                   m;
    quad = a[ANGLE_BITS-1 -: 2];
    r    = a[QUARTER_BITS-1:0];
    q    = quad[0] ? ((QUARTER_BITS+1)'(QUARTER) - {1'b0, r}) : {1'b0, r};
    m    = {1'b0, sine_quarter(q)};
    return quad[1] ? -m : m;
  endfunction

endpackage

// File: src/sqt_cell.sv
module sqt_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic             shift,
  input  sqt_pkg::vertex_t load_data,
  input  logic             nbr_vld,
  input  sqt_pkg::vertex_t nbr_data,
  output logic             vld,
  output sqt_pkg::vertex_t data
);

  logic             vld_r;
  sqt_pkg::vertex_t data_r;

  // Take a fresh vertex on load, else advance from the neighbor on shift.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (shift) begin
      vld_r <= nbr_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end else if (shift) begin
      data_r <= nbr_data;
    end
  end

  assign vld  = vld_r;
  assign data = data_r;

endmodule

// File: src/sqt_xform.sv
module sqt_xform (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         sprite_valid,
  input  sqt_pkg::sprite_t                             sprite,
  output logic                                         sprite_stall,
  output logic                                         quad_valid,
  output sqt_pkg::vertex_t [sqt_pkg::NUM_CORNERS-1:0]  quad,
  input  logic                                         quad_take
);

  localparam int SUM_W = sqt_pkg::SUM_W;

  // Stage control
  logic s1_vld_r, s2_vld_r;
  logic s1_ready, s2_ready;

  assign s2_ready     = !s2_vld_r || quad_take;
  assign s1_ready     = !s1_vld_r || s2_ready;
  assign sprite_stall = !s1_ready;
  assign quad_valid   = s2_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_vld_r <= sprite_valid;
      end
      if (s2_ready) begin
        s2_vld_r <= s1_vld_r;
      end
    end
  end

  // Stage 1: sine and cosine of minus the angle, scaled half sizes, center, texture
  sqt_pkg::angle_t                            ang, neg;
  sqt_pkg::trig_t                             sn_nxt, cs_nxt;
  logic [sqt_pkg::SCALED_W-1:0]               a_nxt, b_nxt;
  logic signed [sqt_pkg::CENTER_W-1:0]        cx_nxt, cy_nxt;
  logic [16:0]                                tu_sum, tv_sum;

  assign ang    = sqt_pkg::angle_t'(sprite.angle);
  assign neg    = sqt_pkg::angle_t'(0) - ang;
  assign sn_nxt = sqt_pkg::sine_full(neg);
  assign cs_nxt = sqt_pkg::sine_full(neg + sqt_pkg::angle_t'(sqt_pkg::QUARTER));
  assign a_nxt  = sqt_pkg::SCALED_W'(sprite.width) * sqt_pkg::SCALED_W'(sprite.scale_x);
  assign b_nxt  = sqt_pkg::SCALED_W'(sprite.height) * sqt_pkg::SCALED_W'(sprite.scale_y);
  assign cx_nxt = (sqt_pkg::CENTER_W'(sprite.left_x) <<< 1) + $signed({2'b00, sprite.width});
  assign cy_nxt = (sqt_pkg::CENTER_W'(sprite.top_y) <<< 1) + $signed({2'b00, sprite.height});
  assign tu_sum = {1'b0, sprite.tex_x} + {1'b0, sprite.tex_w};
  assign tv_sum = {1'b0, sprite.tex_y} + {1'b0, sprite.tex_h};

  sqt_pkg::trig_t                      sn1_r, cs1_r;
  logic [sqt_pkg::SCALED_W-1:0]        a1_r, b1_r;
  logic signed [sqt_pkg::CENTER_W-1:0] cx1_r, cy1_r;
  logic [15:0]                         tu0_1_r, tu1_1_r, tv0_1_r, tv1_1_r;
  logic [31:0]                         col1_r;

  always_ff @(posedge clk) begin
    if (s1_ready && sprite_valid) begin
      sn1_r   <= sn_nxt;
      cs1_r   <= cs_nxt;
      a1_r    <= a_nxt;
      b1_r    <= b_nxt;
      cx1_r   <= cx_nxt;
      cy1_r   <= cy_nxt;
      tu0_1_r <= sprite.tex_x;
      tu1_1_r <= tu_sum[16] ? 16'hFFFF : tu_sum[15:0];
      tv0_1_r <= sprite.tex_y;
      tv1_1_r <= tv_sum[16] ? 16'hFFFF : tv_sum[15:0];
      col1_r  <= sprite.colour;
    end
  end

  // Stage 2: the four rotation products
  logic signed [sqt_pkg::PROD_W-1:0]   pac_r, pas_r, pbs_r, pbc_r;
  logic signed [sqt_pkg::CENTER_W-1:0] cx2_r, cy2_r;
  logic [15:0]                         tu0_2_r, tu1_2_r, tv0_2_r, tv1_2_r;
  logic [31:0]                         col2_r;

  always_ff @(posedge clk) begin
    if (s2_ready && s1_vld_r) begin
      pac_r   <= $signed({1'b0, a1_r}) * cs1_r;
      pas_r   <= $signed({1'b0, a1_r}) * sn1_r;
      pbs_r   <= $signed({1'b0, b1_r}) * sn1_r;
      pbc_r   <= $signed({1'b0, b1_r}) * cs1_r;
      cx2_r   <= cx1_r;
      cy2_r   <= cy1_r;
      tu0_2_r <= tu0_1_r;
      tu1_2_r <= tu1_1_r;
      tv0_2_r <= tv0_1_r;
      tv1_2_r <= tv1_1_r;
      col2_r  <= col1_r;
    end
  end

  // Round half up to Q12.4 and saturate.
  function automatic logic signed [15:0] round_sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    r = (v + (SUM_W'(1) <<< (sqt_pkg::OUT_SHIFT - 1))) >>> sqt_pkg::OUT_SHIFT;
    if (r > SUM_W'(32767)) begin
      return 16'sh7FFF;
    end
    if (r < -SUM_W'(32768)) begin
      return 16'sh8000;
    end
    return r[15:0];
  endfunction

  logic signed [SUM_W-1:0] cxs, cys;

  assign cxs = SUM_W'(cx2_r) <<< sqt_pkg::CENTER_SHIFT;
  assign cys = SUM_W'(cy2_r) <<< sqt_pkg::CENTER_SHIFT;

  // Corner sums: only the signs of the offset products differ per corner
  for (genvar k = 0; k < sqt_pkg::NUM_CORNERS; k++) begin : g_corner
    localparam bit POS_X = (k % 2) == 1;
    localparam bit POS_Y = (k / 2) == 1;

    logic signed [SUM_W-1:0] ac, asn, bs, bc, rx, ry;

    assign ac   = POS_X ? SUM_W'(pac_r) : -SUM_W'(pac_r);
    assign asn  = POS_X ? SUM_W'(pas_r) : -SUM_W'(pas_r);
    assign bs   = POS_Y ? SUM_W'(pbs_r) : -SUM_W'(pbs_r);
    assign bc   = POS_Y ? SUM_W'(pbc_r) : -SUM_W'(pbc_r);
    assign rx   = ac - bs + cxs;
    assign ry   = asn + bc + cys;

    assign quad[k].corner = sqt_pkg::CORNER_BITS'(k);
    assign quad[k].x      = round_sat(rx);
    assign quad[k].y      = round_sat(ry);
    assign quad[k].u      = POS_X ? tu1_2_r : tu0_2_r;
    assign quad[k].v      = POS_Y ? tv1_2_r : tv0_2_r;
    assign quad[k].colour = col2_r;
    assign quad[k].last   = (k == sqt_pkg::NUM_CORNERS - 1);
  end

endmodule

// File: src/sprite_quad_transform.sv
// Flow: a sprite accepted into stage 1 is registered again in stage 2; its four
//   vertices then load into the vertex chain, the first on out_, the rest behind.
// Output: one vertex per transfer shifts out of a four-cell vertex chain; a new
//   sprite loads only when the chain is empty or its last vertex is leaving.
// Reset: synchronous, active low; clears all valid bits, no clearing pass.
module sprite_quad_transform (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_left_x,
  input  logic signed [15:0] in_top_y,
  input  logic [15:0]        in_width,
  input  logic [15:0]        in_height,
  input  logic [15:0]        in_scale_x,
  input  logic [15:0]        in_scale_y,
  input  logic [11:0]        in_angle,
  input  logic [15:0]        in_tex_x,
  input  logic [15:0]        in_tex_y,
  input  logic [15:0]        in_tex_w,
  input  logic [15:0]        in_tex_h,
  input  logic [31:0]        in_colour,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_corner,
  output logic signed [15:0] out_vertex_x,
  output logic signed [15:0] out_vertex_y,
  output logic [15:0]        out_tex_u,
  output logic [15:0]        out_tex_v,
  output logic [31:0]        out_vertex_colour,
  output logic               out_last_corner
);

  localparam int N = sqt_pkg::NUM_CORNERS;

  sqt_pkg::sprite_t                   sprite;
  logic                               quad_valid;
  logic                               quad_take;
  sqt_pkg::vertex_t [N-1:0]           quad;

  // Gather the input fields
  assign sprite.left_x  = in_left_x;
  assign sprite.top_y   = in_top_y;
  assign sprite.width   = in_width;
  assign sprite.height  = in_height;
  assign sprite.scale_x = in_scale_x;
  assign sprite.scale_y = in_scale_y;
  assign sprite.angle   = in_angle;
  assign sprite.tex_x   = in_tex_x;
  assign sprite.tex_y   = in_tex_y;
  assign sprite.tex_w   = in_tex_w;
  assign sprite.tex_h   = in_tex_h;
  assign sprite.colour  = in_colour;

  sqt_xform u_xform (
    .clk          (clk),
    .rst_n        (rst_n),
    .sprite_valid (in_valid),
    .sprite       (sprite),
    .sprite_stall (in_stall),
    .quad_valid   (quad_valid),
    .quad         (quad),
    .quad_take    (quad_take)
  );

  // Vertex chain: cell 0 faces the output, the tail shifts in empty slots
  logic [N:0]       cell_vld;
  sqt_pkg::vertex_t cell_data [N+1];
  logic             out_xfer;
  logic             chain_free;

  assign cell_vld[N]  = 1'b0;
  assign cell_data[N] = '0;

  assign out_xfer   = cell_vld[0] && !out_stall;
  assign chain_free = !cell_vld[0] || (!cell_vld[1] && !out_stall);
  assign quad_take  = quad_valid && chain_free;

  for (genvar i = 0; i < N; i++) begin : g_cell
    sqt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .load      (quad_take),
      .shift     (out_xfer),
      .load_data (quad[i]),
      .nbr_vld   (cell_vld[i+1]),
      .nbr_data  (cell_data[i+1]),
      .vld       (cell_vld[i]),
      .data      (cell_data[i])
    );
  end

  // Drive the result channel from the head cell
  assign out_valid         = cell_vld[0];
  assign out_corner        = cell_data[0].corner;
  assign out_vertex_x      = cell_data[0].x;
  assign out_vertex_y      = cell_data[0].y;
  assign out_tex_u         = cell_data[0].u;
  assign out_tex_v         = cell_data[0].v;
  assign out_vertex_colour = cell_data[0].colour;
  assign out_last_corner   = cell_data[0].last;

endmodule

// File: src/sqt_checker.sv
`include "sprite_quad_transform_defines.svh"

module sqt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_corner,
  input logic signed [15:0] out_vertex_x,
  input logic signed [15:0] out_vertex_y,
  input logic [31:0]        out_vertex_colour,
  input logic               out_last_corner
);

  logic out_xfer;

  assign out_xfer = out_valid && !out_stall;

  // Hold a stalled vertex
  `SQT_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_corner) && $stable(out_vertex_x) && $stable(out_vertex_y))

  // Follow a non-final corner with the next corner at once
  `SQT_ASSERT_NEXT(a_corner_step, out_xfer && !out_last_corner,
    out_valid && (out_corner == $past(out_corner) + 2'd1))

  // Start each sprite at corner zero
  `SQT_ASSERT_NEXT(a_corner_start, out_xfer && out_last_corner,
    !out_valid || (out_corner == 2'd0))

  // Mark the last corner exactly on corner three, keep colour within a sprite
  `SQT_ASSERT_NOW(a_last_mark, out_valid, out_last_corner == (out_corner == 2'd3))
  `SQT_ASSERT_NEXT(a_colour_keep, out_xfer && !out_last_corner,
    out_vertex_colour == $past(out_vertex_colour))

endmodule

bind sprite_quad_transform sqt_checker u_sqt_checker (.*);

// File: sim/tb.sv
module tb;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam int HOLD_OFF_AFTER  = 40;
  localparam int RANDOM_SPRITES  = 350;
  localparam int DRAIN_CYCLES    = 12;

  // Quarter-wave sine in Q1.14, one point every 1/64 turn
  localparam int QUARTER_WAVE [17] = '{
    0, 1606, 3196, 4756, 6270, 7723, 9102, 10394, 11585,
    12665, 13623, 14449, 15137, 15678, 16069, 16305, 16384
  };

  // Expected corner vertices, oldest sprite first
  class vertex_scoreboard;
    sqt_pkg::vertex_t pending[$];
    int               errors;

    function new();
      errors = 0;
    endfunction

    // Interpolated sine over a quarter turn, q in 0..QUARTER
    function int wave_sine(int q);
      int pos;
      int seg;
      int frac;
      int lo;
      int diff;
      pos  = q * 16;
      seg  = pos >> sqt_pkg::QUARTER_BITS;
      frac = pos & (sqt_pkg::QUARTER - 1);
      if (seg >= 16) begin
        return QUARTER_WAVE[16];
      end
      lo   = QUARTER_WAVE[seg];
      diff = QUARTER_WAVE[seg + 1] - lo;
      return lo + ((diff * frac + (1 << (sqt_pkg::QUARTER_BITS - 1)))
                   >> sqt_pkg::QUARTER_BITS);
    endfunction

    // Full-turn sine from the quarter wave by symmetry
    function int turn_sine(int a);
      int quad;
      int r;
      int m;
      a    = a & ((1 << sqt_pkg::ANGLE_BITS) - 1);
      quad = a >> sqt_pkg::QUARTER_BITS;
      r    = a & (sqt_pkg::QUARTER - 1);
      m    = (quad & 1) ? wave_sine(sqt_pkg::QUARTER - r) : wave_sine(r);
      return (quad & 2) ? -m : m;
    endfunction

    // Round half up to Q12.4, then clamp to the signed 16-bit range
    function logic signed [15:0] to_position(longint acc);
      acc = (acc + (longint'(1) << (sqt_pkg::OUT_SHIFT - 1))) >>> sqt_pkg::OUT_SHIFT;
      if (acc > 32767) begin
        acc = 32767;
      end
      if (acc < -32768) begin
        acc = -32768;
      end
      return 16'(acc);
    endfunction

    function logic [15:0] clamp_tex(int sum);
      return (sum > 65535) ? 16'hFFFF : 16'(sum);
    endfunction

    // Work out the four corners of an accepted sprite
    function void add_sprite(sqt_pkg::sprite_t s);
      longint           w;
      longint           h;
      longint           cx;
      longint           cy;
      longint           px;
      longint           py;
      longint           sn;
      longint           cs;
      int               neg;
      sqt_pkg::vertex_t v;
      w   = longint'(s.width);
      h   = longint'(s.height);
      neg = ((1 << sqt_pkg::ANGLE_BITS) - int'(s.angle)) & ((1 << sqt_pkg::ANGLE_BITS) - 1);
      sn  = turn_sine(neg);
      cs  = turn_sine(neg + sqt_pkg::QUARTER);
      cx  = 2 * longint'(s.left_x) + w;
      cy  = 2 * longint'(s.top_y) + h;
      for (int k = 0; k < sqt_pkg::NUM_CORNERS; k++) begin
        px = ((k & 1) ? w : -w) * longint'(s.scale_x);
        py = ((k & 2) ? h : -h) * longint'(s.scale_y);
        v.corner = sqt_pkg::CORNER_BITS'(k);
        v.x      = to_position(px * cs - py * sn
                               + cx * (longint'(1) << sqt_pkg::CENTER_SHIFT));
        v.y      = to_position(px * sn + py * cs
                               + cy * (longint'(1) << sqt_pkg::CENTER_SHIFT));
        v.u      = (k & 1) ? clamp_tex(int'(s.tex_x) + int'(s.tex_w)) : s.tex_x;
        v.v      = (k & 2) ? clamp_tex(int'(s.tex_y) + int'(s.tex_h)) : s.tex_y;
        v.colour = s.colour;
        v.last   = (k == sqt_pkg::NUM_CORNERS - 1);
        pending.push_back(v);
      end
    endfunction

    function void compare(string name, longint want, longint got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Match one vertex transfer against the oldest expectation
    function void check_vertex(sqt_pkg::vertex_t got);
      sqt_pkg::vertex_t want;
      if (pending.size() == 0) begin
        $display("%0t: vertex with no sprite pending, corner %0d x %0d y %0d",
                 $time, got.corner, got.x, got.y);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare("corner", longint'(want.corner), longint'(got.corner));
      compare("vertex_x", longint'(want.x), longint'(got.x));
      compare("vertex_y", longint'(want.y), longint'(got.y));
      compare("tex_u", longint'(want.u), longint'(got.u));
      compare("tex_v", longint'(want.v), longint'(got.v));
      compare("vertex_colour", longint'(want.colour), longint'(got.colour));
      compare("last_corner", longint'(want.last), longint'(got.last));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] in_left_x;
  logic signed [15:0] in_top_y;
  logic [15:0]        in_width;
  logic [15:0]        in_height;
  logic [15:0]        in_scale_x;
  logic [15:0]        in_scale_y;
  logic [11:0]        in_angle;
  logic [15:0]        in_tex_x;
  logic [15:0]        in_tex_y;
  logic [15:0]        in_tex_w;
  logic [15:0]        in_tex_h;
  logic [31:0]        in_colour;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_corner;
  logic signed [15:0] out_vertex_x;
  logic signed [15:0] out_vertex_y;
  logic [15:0]        out_tex_u;
  logic [15:0]        out_tex_v;
  logic [31:0]        out_vertex_colour;
  logic               out_last_corner;

  vertex_scoreboard board = new();
  int               sprites_accepted = 0;
  int               cycle_count = 0;

  sprite_quad_transform DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_left_x         (in_left_x),
    .in_top_y          (in_top_y),
    .in_width          (in_width),
    .in_height         (in_height),
    .in_scale_x        (in_scale_x),
    .in_scale_y        (in_scale_y),
    .in_angle          (in_angle),
    .in_tex_x          (in_tex_x),
    .in_tex_y          (in_tex_y),
    .in_tex_w          (in_tex_w),
    .in_tex_h          (in_tex_h),
    .in_colour         (in_colour),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_corner        (out_corner),
    .out_vertex_x      (out_vertex_x),
    .out_vertex_y      (out_vertex_y),
    .out_tex_u         (out_tex_u),
    .out_tex_v         (out_tex_v),
    .out_vertex_colour (out_vertex_colour),
    .out_last_corner   (out_last_corner)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic sqt_pkg::sprite_t make_sprite(int lx, int ty, int wd, int ht,
                                                   int sx, int sy, int ang,
                                                   int ux, int vy, int uw, int vh,
                                                   logic [31:0] col);
    sqt_pkg::sprite_t s;
    s.left_x  = 16'(lx);
    s.top_y   = 16'(ty);
    s.width   = 16'(wd);
    s.height  = 16'(ht);
    s.scale_x = 16'(sx);
    s.scale_y = 16'(sy);
    s.angle   = 12'(ang);
    s.tex_x   = 16'(ux);
    s.tex_y   = 16'(vy);
    s.tex_w   = 16'(uw);
    s.tex_h   = 16'(vh);
    s.colour  = col;
    return s;
  endfunction

  // Mostly on-screen sprites near unit scale, the rest with raw random fields
  function automatic sqt_pkg::sprite_t random_sprite();
    sqt_pkg::sprite_t s;
    s.left_x  = 16'($urandom);
    s.top_y   = 16'($urandom);
    s.width   = 16'($urandom);
    s.height  = 16'($urandom);
    s.scale_x = 16'($urandom);
    s.scale_y = 16'($urandom);
    s.angle   = 12'($urandom);
    s.tex_x   = 16'($urandom);
    s.tex_y   = 16'($urandom);
    s.tex_w   = 16'($urandom);
    s.tex_h   = 16'($urandom);
    s.colour  = $urandom;
    if ($urandom_range(0, 9) < 7) begin
      s.left_x  = 16'($urandom_range(0, 16000) - 8000);
      s.top_y   = 16'($urandom_range(0, 16000) - 8000);
      s.width   = 16'($urandom_range(0, 8192));
      s.height  = 16'($urandom_range(0, 8192));
      s.scale_x = 16'($urandom_range(0, 12288));
      s.scale_y = 16'($urandom_range(0, 12288));
      s.tex_w   = 16'($urandom_range(0, 16384));
      s.tex_h   = 16'($urandom_range(0, 16384));
    end
    return s;
  endfunction

  // Offer one sprite and hold it until the transfer
  task automatic send_sprite(input sqt_pkg::sprite_t s);
    in_valid   <= 1'b1;
    in_left_x  <= s.left_x;
    in_top_y   <= s.top_y;
    in_width   <= s.width;
    in_height  <= s.height;
    in_scale_x <= s.scale_x;
    in_scale_y <= s.scale_y;
    in_angle   <= s.angle;
    in_tex_x   <= s.tex_x;
    in_tex_y   <= s.tex_y;
    in_tex_w   <= s.tex_w;
    in_tex_h   <= s.tex_h;
    in_colour  <= s.colour;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.add_sprite(s);
    sprites_accepted++;
  endtask

  // Check every vertex transfer
  always @(posedge clk) begin
    sqt_pkg::vertex_t got;
    got.corner = out_corner;
    got.x      = out_vertex_x;
    got.y      = out_vertex_y;
    got.u      = out_tex_u;
    got.v      = out_tex_v;
    got.colour = out_vertex_colour;
    got.last   = out_last_corner;
    if (rst_n && out_valid && !out_stall) begin
      board.check_vertex(got);
    end
  end

  // Stall the result side in runs of varying density, with one long hold-off
  initial begin
    int  run_left;
    int  mode;
    int  hold_count;
    bit  held_off;
    run_left  = 0;
    mode      = 0;
    held_off  = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held_off && sprites_accepted >= HOLD_OFF_AFTER) begin
        held_off   = 1'b1;
        out_stall <= 1'b1;
        hold_count = 0;
        while (hold_count < HOLD_OFF_CYCLES) begin
          @(posedge clk);
          hold_count++;
        end
      end else begin
        if (run_left == 0) begin
          mode     = $urandom_range(0, 3);
          run_left = $urandom_range(5, 60);
        end
        run_left--;
        unique case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 99) < 40);
          2:       out_stall <= ($urandom_range(0, 99) < 85);
          default: out_stall <= run_left[1];
        endcase
      end
    end
  end

  // Stimulus: directed corners of the space, then random sprites in bursts
  initial begin
    sqt_pkg::sprite_t plan[$];
    int               idx;
    int               burst;
    int               gap;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_left_x  <= '0;
    in_top_y   <= '0;
    in_width   <= '0;
    in_height  <= '0;
    in_scale_x <= '0;
    in_scale_y <= '0;
    in_angle   <= '0;
    in_tex_x   <= '0;
    in_tex_y   <= '0;
    in_tex_w   <= '0;
    in_tex_h   <= '0;
    in_colour  <= '0;

    // all fields at zero, all at maximum, then minimum positions with maximum sizes
    plan.push_back(make_sprite(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0));
    plan.push_back(make_sprite(32767, 32767, 65535, 65535, 65535, 65535, 4095,
                               65535, 65535, 65535, 65535, 32'hFFFFFFFF));
    plan.push_back(make_sprite(-32768, -32768, 65535, 65535, 65535, 65535, 2048,
                               0, 0, 0, 0, 32'h0));
    // unit-scale sprite at the quarter turns and between table points, then larger sprites at more angles and scales
    plan.push_back(make_sprite(1600, 800, 512, 256, 4096, 4096, 0,
                               0, 0, 32768, 32768, 32'hAAAA5555));
    plan.push_back(make_sprite(1600, 800, 512, 256, 4096, 4096, 1024,
                               4096, 8192, 16384, 16384, 32'h5555AAAA));
    plan.push_back(make_sprite(1600, 800, 512, 256, 4096, 4096, 2048,
                               100, 200, 300, 400, 32'h12345678));
    plan.push_back(make_sprite(1600, 800, 512, 256, 4096, 4096, 3072,
                               0, 0, 65535, 65535, 32'h80000001));
    plan.push_back(make_sprite(-1600, -800, 512, 256, 4096, 4096, 1,
                               0, 0, 1, 1, 32'hFF00FF00));
    plan.push_back(make_sprite(-1600, -800, 512, 256, 4096, 4096, 4095,
                               0, 0, 1, 1, 32'h00FF00FF));
    plan.push_back(make_sprite(0, 0, 4000, 4000, 8192, 4096, 512,
                               0, 0, 0, 0, 32'h0F0F0F0F));
    plan.push_back(make_sprite(0, 0, 4000, 4000, 4096, 8192, 64,
                               0, 0, 0, 0, 32'hF0F0F0F0));
    plan.push_back(make_sprite(0, 0, 4000, 4000, 4096, 4096, 8,
                               0, 0, 0, 0, 32'h1));
    plan.push_back(make_sprite(0, 0, 4000, 4000, 4096, 4096, 1023,
                               0, 0, 0, 0, 32'h2));
    plan.push_back(make_sprite(0, 0, 4000, 4000, 4096, 4096, 3000,
                               0, 0, 0, 0, 32'h3));
    // zero scale and zero size collapse onto the center
    plan.push_back(make_sprite(1234, -4321, 40000, 30000, 0, 0, 700,
                               0, 0, 0, 0, 32'h4));
    plan.push_back(make_sprite(-1234, 4321, 0, 0, 65535, 65535, 1500,
                               0, 0, 0, 0, 32'h5));
    // positions past either end of the range
    plan.push_back(make_sprite(32000, 32000, 4000, 4000, 16384, 16384, 0,
                               0, 0, 0, 0, 32'h6));
    plan.push_back(make_sprite(-32000, -32000, 4000, 4000, 16384, 16384, 2048,
                               0, 0, 0, 0, 32'h7));
    plan.push_back(make_sprite(0, 0, 65535, 65535, 65535, 65535, 300,
                               0, 0, 0, 0, 32'h8));
    // texture sums over and exactly at the top
    plan.push_back(make_sprite(0, 0, 160, 160, 4096, 4096, 0,
                               16'hF000, 16'hFFFF, 16'h2000, 1, 32'h9));
    plan.push_back(make_sprite(0, 0, 160, 160, 4096, 4096, 0,
                               16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 32'hA));
    repeat (RANDOM_SPRITES) plan.push_back(random_sprite());

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Send in bursts separated by random gaps
    idx = 0;
    while (idx < plan.size()) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && idx < plan.size()) begin
        send_sprite(plan[idx]);
        idx++;
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding vertices, then watch for strays
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
